FILE: rtl/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

    // Bitmap geometry: one used bit per page, packed into fixed-width words.
    localparam int WORD_BITS     = 32;
    localparam int WORD_LOG      = 5;
    localparam int PAGE_BYTES    = 4096;
    localparam int PAGE_LOG      = 12;
    localparam int MAP_WORDS_DEF = 4096;

    // Field widths of the request and response words.
    localparam int ADDR_W = 29;
    localparam int SIZE_W = 30;

    // Page numbers and page sums; wide enough for the largest map and the largest range end.
    localparam int PG_W = 22;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [1:0] {
        FUNC_ALLOC      = 2'd0,
        FUNC_FREE_PAGE  = 2'd1,
        FUNC_FREE_RANGE = 2'd2,
        FUNC_RESERVE    = 2'd3
    } func_t;

    typedef struct packed {
        func_t              func;
        logic [ADDR_W-1:0]  address;
        logic [SIZE_W-1:0]  size;
    } req_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  page_address;
        logic               ok;
    } rsp_word_t;

    // Index of the lowest clear bit; the lowest set bit of the inverted word is isolated first.
    function automatic logic [WORD_LOG-1:0] lowest_clear(input word_t value);
        word_t                inv;
        word_t                onehot;
        logic [WORD_LOG-1:0]  idx;
        inv    = ~value;
        onehot = inv & (~inv + word_t'(1));
        idx    = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            idx = idx | (onehot[b] ? WORD_LOG'(b) : '0);
        end
        return idx;
    endfunction

    // Ones from bit lo up to and including bit hi.
    function automatic word_t range_mask(input logic [WORD_LOG-1:0] lo,
                                         input logic [WORD_LOG-1:0] hi);
        word_t ones;
        ones = '1;
        return (ones << lo) & (ones >> (WORD_LOG'(WORD_BITS - 1) - hi));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bitmap_page_allocator_unit.sv
`default_nettype none

// Physical page allocator with one used bit per 4 KiB page, held in a single-port-write,
// registered-read bitmap memory of MAP_WORDS words of 32 bits. After reset the block runs
// a clearing pass that marks every page used, and takes no request word until it ends.
// One request word is worked at a time, and each gives one response word. A range of no
// whole pages, or one that starts beyond the map, is answered without touching the map;
// otherwise the walk reads and writes back one word per cycle over every bitmap word that
// the range touches. Alloc scans words one per cycle from a hint below which all words are
// known full: a grant comes from the first word read that is not full, and a refusal when
// every word from the hint to the end is full. The block goes back to idle when the
// response is loaded, and takes the next request word there. A finished response waits
// in an output register, so a new request word can be taken while the last response is
// stalled; the block only waits if a second response is ready before the first leaves.
module bitmap_page_allocator_unit #(
    parameter int MAP_WORDS = bpa_pkg::MAP_WORDS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire bpa_pkg::req_word_t  req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output bpa_pkg::rsp_word_t       rsp
);

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic                           mem_re;
    logic [AW-1:0]                  mem_raddr;
    logic [bpa_pkg::WORD_BITS-1:0]  mem_rdata;
    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [bpa_pkg::WORD_BITS-1:0]  mem_wdata;

    // Operation sequencer.
    bpa_seq #(
        .MAP_WORDS (MAP_WORDS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

    // Used-page bitmap.
    bpa_ram #(
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata)
    );

endmodule

`default_nettype wire

FILE: rtl/bpa_ram.sv
`default_nettype none

module bpa_ram #(
    parameter int DEPTH = bpa_pkg::MAP_WORDS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [bpa_pkg::WORD_BITS-1:0]               rdata,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [bpa_pkg::WORD_BITS-1:0]          wdata
);

    bpa_pkg::word_t mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bpa_seq.sv
`default_nettype none

module bpa_seq #(
    parameter int MAP_WORDS = bpa_pkg::MAP_WORDS_DEF
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         req_valid,
    output logic                                              req_stall,
    input  wire bpa_pkg::req_word_t                           req,
    output logic                                              rsp_valid,
    input  wire logic                                         rsp_stall,
    output bpa_pkg::rsp_word_t                                rsp,
    output logic                                              mem_re,
    output logic [((MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1)-1:0] mem_raddr,
    input  wire logic [bpa_pkg::WORD_BITS-1:0]                mem_rdata,
    output logic                                              mem_we,
    output logic [((MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1)-1:0] mem_waddr,
    output logic [bpa_pkg::WORD_BITS-1:0]                     mem_wdata
);

    localparam int AW      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CW      = AW + 1;
    localparam int PW      = bpa_pkg::PG_W;
    localparam int WL      = bpa_pkg::WORD_LOG;
    localparam int CNT_W   = bpa_pkg::SIZE_W - bpa_pkg::PAGE_LOG;
    localparam int ADDR_W  = bpa_pkg::ADDR_W;
    localparam int FULL_AW = AW + WL + bpa_pkg::PAGE_LOG;

    localparam logic [PW-1:0] TOTAL_PAGES = PW'(MAP_WORDS * bpa_pkg::WORD_BITS);
    localparam logic [PW-1:0] LAST_PAGE   = PW'(MAP_WORDS * bpa_pkg::WORD_BITS - 1);
    localparam logic [CW-1:0] WORDS_END   = CW'(MAP_WORDS);
    localparam logic [AW-1:0] LAST_WORD   = AW'(MAP_WORDS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_RANGE,
        S_DRAIN,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                 state_reg,   state_next;
    bpa_pkg::func_t         func_reg,    func_next;
    logic [PW-1:0]          first_reg,   first_next;
    logic [CNT_W-1:0]       cnt_reg,     cnt_next;
    logic [PW-1:0]          last_reg,    last_next;
    logic [CW-1:0]          rd_cnt_reg,  rd_cnt_next;
    logic [CW-1:0]          hint_reg,    hint_next;
    logic                   p_valid_reg, p_valid_next;
    logic [AW-1:0]          p_word_reg,  p_word_next;
    logic [WL-1:0]          p_lo_reg,    p_lo_next;
    logic [WL-1:0]          p_hi_reg,    p_hi_next;
    bpa_pkg::rsp_word_t     res_reg,     res_next;
    bpa_pkg::rsp_word_t     out_reg,     out_next;
    logic                   out_valid_reg, out_valid_next;

    logic [AW-1:0]          first_word;
    logic [AW-1:0]          last_word;
    logic [AW-1:0]          rd_word;
    logic [PW-1:0]          end_page;
    logic                   no_op;
    logic                   issue;
    logic                   word_full;
    logic [WL-1:0]          clear_idx;
    bpa_pkg::word_t         mask;
    logic [FULL_AW-1:0]     page_bytes;
    logic [ADDR_W+FULL_AW-1:0] page_wide;

    // Decoded range bounds and scan helpers.
    always_comb
    begin
        first_word = first_reg[WL +: AW];
        last_word  = last_reg[WL +: AW];
        rd_word    = rd_cnt_reg[AW-1:0];
        end_page   = first_reg + PW'(cnt_reg) - PW'(1);
        no_op      = (first_reg >= TOTAL_PAGES) || (cnt_reg == '0);
        issue      = rd_cnt_reg < WORDS_END;
        word_full  = mem_rdata == '1;
        clear_idx  = bpa_pkg::lowest_clear(mem_rdata);
        mask       = bpa_pkg::range_mask(p_lo_reg, p_hi_reg);
        page_bytes = {p_word_reg, clear_idx, {bpa_pkg::PAGE_LOG{1'b0}}};
        page_wide  = {{ADDR_W{1'b0}}, page_bytes};
    end

    // Sequencer: clearing pass, range walk, allocation scan and result hand-off.
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        first_next     = first_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        rd_cnt_next    = rd_cnt_reg;
        hint_next      = hint_reg;
        p_valid_next   = 1'b0;
        p_word_next    = p_word_reg;
        p_lo_next      = p_lo_reg;
        p_hi_next      = p_hi_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_re         = 1'b0;
        mem_raddr      = rd_word;
        mem_we         = 1'b0;
        mem_waddr      = p_word_reg;
        mem_wdata      = mem_rdata;

        // The response word leaves when the consumer takes it.
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = rd_word;
                mem_wdata = '1;
                if (rd_word == LAST_WORD)
                begin
                    rd_cnt_next = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg + CW'(1);
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next  = req.func;
                    first_next = PW'(req.address[ADDR_W-1:bpa_pkg::PAGE_LOG]);
                    if (req.func == bpa_pkg::FUNC_FREE_PAGE)
                    begin
                        cnt_next = CNT_W'(1);
                    end
                    else
                    begin
                        cnt_next = req.size[bpa_pkg::SIZE_W-1:bpa_pkg::PAGE_LOG];
                    end
                    state_next = S_SETUP;
                end
            end

            S_SETUP:
            begin
                last_next = (end_page > LAST_PAGE) ? LAST_PAGE : end_page;
                res_next  = '{page_address: '0, ok: 1'b1};
                if (func_reg == bpa_pkg::FUNC_ALLOC)
                begin
                    rd_cnt_next = hint_reg;
                    state_next  = S_SCAN;
                end
                else if (no_op)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_cnt_next = {1'b0, first_word};
                    // Freed pages below the hint move the scan start down.
                    if (func_reg != bpa_pkg::FUNC_RESERVE && {1'b0, first_word} < hint_reg)
                    begin
                        hint_next = {1'b0, first_word};
                    end
                    state_next = S_RANGE;
                end
            end

            S_RANGE:
            begin
                mem_re       = 1'b1;
                p_valid_next = 1'b1;
                p_word_next  = rd_word;
                p_lo_next    = (rd_word == first_word) ? first_reg[WL-1:0] : '0;
                p_hi_next    = (rd_word == last_word) ? last_reg[WL-1:0] : '1;
                if (rd_word == last_word)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg + CW'(1);
                end
                if (p_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = (func_reg == bpa_pkg::FUNC_RESERVE) ?
                                (mem_rdata | mask) : (mem_rdata & ~mask);
                end
            end

            S_DRAIN:
            begin
                mem_we     = p_valid_reg;
                mem_wdata  = (func_reg == bpa_pkg::FUNC_RESERVE) ?
                             (mem_rdata | mask) : (mem_rdata & ~mask);
                state_next = S_FINISH;
            end

            S_SCAN:
            begin
                if (p_valid_reg && !word_full)
                begin
                    // First word with a clear bit: take its lowest clear bit.
                    mem_we     = 1'b1;
                    mem_wdata  = mem_rdata | (bpa_pkg::word_t'(1) << clear_idx);
                    res_next   = '{page_address: page_wide[ADDR_W-1:0], ok: 1'b1};
                    hint_next  = {1'b0, p_word_reg};
                    state_next = S_FINISH;
                end
                else if (!p_valid_reg && !issue)
                begin
                    // Every word from the hint to the end is full.
                    res_next   = '{page_address: '0, ok: 1'b0};
                    hint_next  = WORDS_END;
                    state_next = S_FINISH;
                end
                else if (issue)
                begin
                    mem_re       = 1'b1;
                    p_valid_next = 1'b1;
                    p_word_next  = rd_word;
                    rd_cnt_next  = rd_cnt_reg + CW'(1);
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            func_reg      <= bpa_pkg::FUNC_ALLOC;
            first_reg     <= '0;
            cnt_reg       <= '0;
            last_reg      <= '0;
            rd_cnt_reg    <= '0;
            hint_reg      <= WORDS_END;
            p_valid_reg   <= 1'b0;
            p_word_reg    <= '0;
            p_lo_reg      <= '0;
            p_hi_reg      <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            first_reg     <= first_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            rd_cnt_reg    <= rd_cnt_next;
            hint_reg      <= hint_next;
            p_valid_reg   <= p_valid_next;
            p_word_reg    <= p_word_next;
            p_lo_reg      <= p_lo_next;
            p_hi_reg      <= p_hi_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire
